/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/gds_pkg.sv */
// ----------------------------------------------------------------------------
// Gregorian day stepper package
// Command and status codes, calendar constants and shared helper functions.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam int DEFAULT_YEAR_WIDTH = 14;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_NEXT = 2'd1,
    CMD_PREV = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST_DEC = 5'd31;

  // Odd factor of a century; a year is a multiple of 100 when it is a
  // multiple of 4 and of this factor, and of 400 when of 16 and this factor.
  localparam logic [63:0] CENTURY_ODD = 64'd25;

  // Length of a month, 1..12. Other codes are screened out by the caller.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Inverse of an odd number modulo 2^64, by Newton iteration. Used only to
  // build constants at elaboration.
  function automatic logic [63:0] inv_mod64(input logic [63:0] a);
    logic [63:0] x;
    x = a;
    for (int i = 0; i < 6; i++) begin
      x = x * (64'd2 - a * x);
    end
    return x;
  endfunction

endpackage

/* hdl/gds_date_core.sv */
// ----------------------------------------------------------------------------
// Gregorian day stepper date core
// Next date and status for one command, from the held date and the load data.
// ----------------------------------------------------------------------------
module gds_date_core import gds_pkg::*; #(
  parameter int YEAR_WIDTH = DEFAULT_YEAR_WIDTH
) (
  input  cmd_t                  cmd,
  input  logic [4:0]            ld_day,
  input  logic [3:0]            ld_month,
  input  logic [YEAR_WIDTH-1:0] ld_year,
  input  logic [4:0]            cur_day,
  input  logic [3:0]            cur_month,
  input  logic [YEAR_WIDTH-1:0] cur_year,
  output logic [4:0]            day_next,
  output logic [3:0]            month_next,
  output logic [YEAR_WIDTH-1:0] year_next,
  output status_t               status
);

  localparam logic [63:0] YEAR_ALL = (64'd1 << YEAR_WIDTH) - 64'd1;
  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = YEAR_WIDTH'(YEAR_ALL);
  localparam logic [YEAR_WIDTH-1:0] YEAR_ONE = YEAR_WIDTH'(1);
  // A multiple of 25 times the modular inverse of 25 lands at or below this.
  localparam logic [YEAR_WIDTH-1:0] INV_ODD = YEAR_WIDTH'(inv_mod64(CENTURY_ODD));
  localparam logic [YEAR_WIDTH-1:0] LIM_ODD = YEAR_WIDTH'(YEAR_ALL / CENTURY_ODD);

  logic [YEAR_WIDTH-1:0] cur_prod, ld_prod;
  logic                  cur_leap, ld_leap;
  logic [4:0]            cur_len, prev_len, ld_len;
  logic [3:0]            prev_month;
  logic                  ld_ok;

  assign cur_prod = cur_year * INV_ODD;
  assign ld_prod  = ld_year * INV_ODD;

  // Leap: divisible by 4, and either not by 25 or also by 16.
  assign cur_leap = (cur_year[1:0] == 2'd0) && ((cur_prod > LIM_ODD) || (cur_year[3:0] == 4'd0));
  assign ld_leap  = (ld_year[1:0] == 2'd0) && ((ld_prod > LIM_ODD) || (ld_year[3:0] == 4'd0));

  assign prev_month = cur_month - 4'd1;
  assign cur_len    = month_len(cur_month, cur_leap);
  assign prev_len   = month_len(prev_month, cur_leap);
  assign ld_len     = month_len(ld_month, ld_leap);

  assign ld_ok = (ld_year != '0) && (ld_month != 4'd0) && (ld_month <= MONTH_DEC) &&
                 (ld_day != 5'd0) && (ld_day <= ld_len);

  always_comb begin
    day_next   = cur_day;
    month_next = cur_month;
    year_next  = cur_year;
    status     = STATUS_OK;
    unique case (cmd)
      CMD_LOAD: begin
        if (ld_ok) begin
          day_next   = ld_day;
          month_next = ld_month;
          year_next  = ld_year;
        end else begin
          status = STATUS_INVALID;
        end
      end
      CMD_NEXT: begin
        priority if (cur_day < cur_len) begin
          day_next = cur_day + 5'd1;
        end else if (cur_month < MONTH_DEC) begin
          day_next   = DAY_FIRST;
          month_next = cur_month + 4'd1;
        end else if (cur_year != YEAR_MAX) begin
          day_next   = DAY_FIRST;
          month_next = MONTH_JAN;
          year_next  = cur_year + YEAR_ONE;
        end else begin
          status = STATUS_RANGE;
        end
      end
      CMD_PREV: begin
        priority if (cur_day > DAY_FIRST) begin
          day_next = cur_day - 5'd1;
        end else if (cur_month > MONTH_JAN) begin
          month_next = prev_month;
          day_next   = prev_len;
        end else if (cur_year > YEAR_ONE) begin
          year_next  = cur_year - YEAR_ONE;
          month_next = MONTH_DEC;
          day_next   = DAY_LAST_DEC;
        end else begin
          status = STATUS_RANGE;
        end
      end
      CMD_READ: begin
        status = STATUS_OK;
      end
    endcase
  end

endmodule

/* hdl/gregorian_day_stepper_top.sv */
// A command taken into the input stage moves into the result register once
// that register is empty or its result is being taken, and is offered there.
// Throughput: one command per cycle while m_tready is high.
// Reset: synchronous, active-high rst empties both stages and sets the date
// to 1 January of year 1. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// Gregorian day stepper top level
// Holds a Gregorian date and applies load, next day, previous day or read
// commands, returning the date and a status for every command.
// ----------------------------------------------------------------------------
module gregorian_day_stepper_top import gds_pkg::*; #(
  parameter int YEAR_WIDTH = DEFAULT_YEAR_WIDTH,
  localparam int DATA_W = ((9 + YEAR_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // load_day, load_month, load_year, zero pad
  input  logic [1:0]        s_tuser,   // command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // day_out, month_out, year_out, zero pad
  output logic [1:0]        m_tuser    // status
);

  localparam int PAD_W = DATA_W - 9 - YEAR_WIDTH;

  // Input stage: one command waits here until the result register is free.
  logic                  in_valid;
  cmd_t                  in_cmd;
  logic [4:0]            in_day;
  logic [3:0]            in_month;
  logic [YEAR_WIDTH-1:0] in_year;

  // Result register.
  logic                  out_valid;
  logic [4:0]            out_day;
  logic [3:0]            out_month;
  logic [YEAR_WIDTH-1:0] out_year;
  status_t               out_status;

  // The held date. It is updated in the same cycle the command moves into the
  // result register, so the next command sees the new date straight away.
  logic [4:0]            cur_day;
  logic [3:0]            cur_month;
  logic [YEAR_WIDTH-1:0] cur_year;

  logic [4:0]            day_next;
  logic [3:0]            month_next;
  logic [YEAR_WIDTH-1:0] year_next;
  status_t               status_next;

  logic                  advance;

  // A command leaves the input stage whenever the result register is empty or
  // its result is being taken in this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd   <= cmd_t'(s_tuser);
      in_day   <= s_tdata[4:0];
      in_month <= s_tdata[8:5];
      in_year  <= s_tdata[9 +: YEAR_WIDTH];
    end
  end

  gds_date_core #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_core (
    .cmd        (in_cmd),
    .ld_day     (in_day),
    .ld_month   (in_month),
    .ld_year    (in_year),
    .cur_day    (cur_day),
    .cur_month  (cur_month),
    .cur_year   (cur_year),
    .day_next   (day_next),
    .month_next (month_next),
    .year_next  (year_next),
    .status     (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= DAY_FIRST;
      cur_month <= MONTH_JAN;
      cur_year  <= YEAR_WIDTH'(1);
    end else if (advance) begin
      cur_day   <= day_next;
      cur_month <= month_next;
      cur_year  <= year_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_day    <= day_next;
      out_month  <= month_next;
      out_year   <= year_next;
      out_status <= status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_year, out_month, out_day};
  assign m_tuser  = out_status;

endmodule

/* hdl/gds_checker.sv */
// ----------------------------------------------------------------------------
// Gregorian day stepper checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gds_checker import gds_pkg::*; #(
  parameter int YEAR_WIDTH = DEFAULT_YEAR_WIDTH,
  localparam int DATA_W = ((9 + YEAR_WIDTH + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic [1:0]        m_tuser
);

  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = '1;
  localparam logic [YEAR_WIDTH-1:0] YEAR_ONE = YEAR_WIDTH'(1);

  logic [4:0]            day_out;
  logic [3:0]            month_out;
  logic [YEAR_WIDTH-1:0] year_out;
  logic                  date_ok;
  logic                  at_first;
  logic                  at_last;
  logic                  range_flag;
  logic                  stalled;
  logic [DATA_W+1:0]     out_word;

  assign day_out   = m_tdata[4:0];
  assign month_out = m_tdata[8:5];
  assign year_out  = m_tdata[9 +: YEAR_WIDTH];

  assign date_ok    = (day_out != 5'd0) && (month_out != 4'd0) &&
                      (month_out <= MONTH_DEC) && (year_out != '0);
  assign at_first   = (day_out == DAY_FIRST) && (month_out == MONTH_JAN) &&
                      (year_out == YEAR_ONE);
  assign at_last    = (day_out == DAY_LAST_DEC) && (month_out == MONTH_DEC) &&
                      (year_out == YEAR_MAX);
  assign range_flag = m_tvalid && (m_tuser == STATUS_RANGE);
  assign stalled    = m_tvalid && !m_tready;
  assign out_word   = {m_tuser, m_tdata};

  // Reset leaves no result pending.
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  // Every reported date has a nonzero day and year and a month from 1 to 12.
  `CHK_ASSERT(a_date_sane, clk, rst, m_tvalid |-> date_ok, "result date out of range")

  // A range error is only possible at either end of the calendar.
  `CHK_ASSERT(a_range_edge, clk, rst, range_flag |-> (at_first || at_last), "range error off ends")

  // A stalled result stays offered and unchanged.
  `CHK_ASSERT(a_hold_valid, clk, rst, stalled |=> m_tvalid, "result dropped while stalled")
  `CHK_ASSERT(a_hold_data, clk, rst, stalled |=> $stable(out_word), "stalled result changed")

endmodule

bind gregorian_day_stepper_top gds_checker #(
  .YEAR_WIDTH (YEAR_WIDTH)
) u_gds_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* test/tb_gregorian_day_stepper_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gregorian day stepper testbench
// Drives load, next day, previous day and read commands into the stream input,
// tracks the calendar date in a scoreboard and checks every returned date and
// status. Both stream sides idle at random, and the output is held off once
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_gregorian_day_stepper_top import gds_pkg::*;;

  localparam int YW = DEFAULT_YEAR_WIDTH;
  localparam int DATA_W = ((9 + YW + 7) / 8) * 8;
  localparam logic [YW-1:0] YEAR_MAX = '1;
  localparam int NUM_RANDOM = 450;
  // Random commands with an index from QUIET_FIRST to QUIET_LAST run with both sides always ready.
  localparam int QUIET_FIRST = 250;
  localparam int QUIET_LAST = 349;
  // Random command index at which the receiver starts its long hold-off.
  localparam int HOLD_AT = 100;
  localparam int HOLD_CYCLES = 80;

  // One expected transfer on the output side.
  typedef struct packed {
    logic [4:0]    day;
    logic [3:0]    month;
    logic [YW-1:0] year;
    status_t       status;
  } date_result_t;

  // Tracks the calendar date as the block should hold it and keeps the
  // results that are owed, oldest first.
  class date_scoreboard;
    logic [4:0]    day;
    logic [3:0]    month;
    logic [YW-1:0] year;
    date_result_t  owed_dates[$];
    int            errors;

    function new();
      day = DAY_FIRST;
      month = MONTH_JAN;
      year = YW'(1);
      errors = 0;
    endfunction

    // Full Gregorian rule: every fourth year, except centuries not divisible
    // by 400.
    function logic [4:0] days_in_month(logic [3:0] m, logic [YW-1:0] y);
      bit leap;
      leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
      case (m)
        MONTH_FEB:               return leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
        default:                 return 5'd31;
      endcase
    endfunction

    function void note_command(cmd_t cmd, logic [4:0] ld, logic [3:0] lm,
                               logic [YW-1:0] ly);
      date_result_t exp_r;
      status_t      st;
      st = STATUS_OK;
      case (cmd)
        CMD_LOAD: begin
          if (ly != 0 && lm >= MONTH_JAN && lm <= MONTH_DEC && ld >= DAY_FIRST &&
              ld <= days_in_month(lm, ly)) begin
            day = ld;
            month = lm;
            year = ly;
          end else begin
            st = STATUS_INVALID;
          end
        end
        CMD_NEXT: begin
          if (day < days_in_month(month, year)) begin
            day = day + 5'd1;
          end else if (month < MONTH_DEC) begin
            day = DAY_FIRST;
            month = month + 4'd1;
          end else if (year < YEAR_MAX) begin
            day = DAY_FIRST;
            month = MONTH_JAN;
            year = year + YW'(1);
          end else begin
            st = STATUS_RANGE;
          end
        end
        CMD_PREV: begin
          if (day > DAY_FIRST) begin
            day = day - 5'd1;
          end else if (month > MONTH_JAN) begin
            month = month - 4'd1;
            day = days_in_month(month, year);
          end else if (year > 1) begin
            year = year - YW'(1);
            month = MONTH_DEC;
            day = DAY_LAST_DEC;
          end else begin
            st = STATUS_RANGE;
          end
        end
        default: begin
        end
      endcase
      exp_r.day = day;
      exp_r.month = month;
      exp_r.year = year;
      exp_r.status = st;
      owed_dates.insert(owed_dates.size(), exp_r);
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic [1:0] st);
      date_result_t exp_r;
      if (owed_dates.size() == 0) begin
        $error("result with nothing owed: day_out %0d month_out %0d year_out %0d",
               data[4:0], data[8:5], data[9 +: YW]);
        errors++;
        return;
      end
      exp_r = owed_dates.pop_front();
      if (data[4:0] !== exp_r.day) begin
        $error("day_out expected %0d, got %0d", exp_r.day, data[4:0]);
        errors++;
      end
      if (data[8:5] !== exp_r.month) begin
        $error("month_out expected %0d, got %0d", exp_r.month, data[8:5]);
        errors++;
      end
      if (data[9 +: YW] !== exp_r.year) begin
        $error("year_out expected %0d, got %0d", exp_r.year, data[9 +: YW]);
        errors++;
      end
      if (st !== exp_r.status) begin
        $error("status expected %0d, got %0d", exp_r.status, st);
        errors++;
      end
    endfunction

    function int pending();
      return owed_dates.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // load_day, load_month, load_year, zero pad
  logic [1:0]        s_tuser = '0;   // command
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // day_out, month_out, year_out, zero pad
  logic [1:0]        m_tuser;        // status

  // Set by the stimulus: quiet turns off random idling on both sides, and
  // hold_request asks the receiver for one long hold-off.
  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  date_scoreboard calendar = new();

  always #5 clk = ~clk;

  gregorian_day_stepper_top #(
    .YEAR_WIDTH(YW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // Offers one command, with a random idle gap in front of it, and returns at
  // the edge where the transfer happens. The scoreboard learns of the command
  // only once the block has taken it. Valid stays high between back-to-back
  // transfers, so it never gets two assignments in one time step.
  task automatic send_command(cmd_t cmd, logic [4:0] ld, logic [3:0] lm,
                              logic [YW-1:0] ly);
    while (!quiet && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DATA_W'({ly, lm, ld});
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    calendar.note_command(cmd, ld, lm, ly);
  endtask

  // Output side. Results are sampled at the edge, before this process updates
  // ready for the next cycle. The long hold-off is counted here, so the sender
  // keeps offering commands while the block fills up behind a stalled output.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        calendar.check_result(m_tdata, m_tuser);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin
    cmd_t          cmd;
    logic [4:0]    ld;
    logic [3:0]    lm;
    logic [YW-1:0] ly;
    logic [4:0]    month_days;
    int            pick;
    int            tail;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reading right after reset must give 1 January of year 1,
    // with the unused load fields all ones to show they are ignored.
    send_command(CMD_READ, 5'd31, 4'd15, YEAR_MAX);
    // Stepping back from the very first date is out of range.
    send_command(CMD_PREV, 5'd0, 4'd0, '0);
    send_command(CMD_NEXT, 5'd0, 4'd0, '0);
    // Loads that must be rejected: zero day, zero month, months past December,
    // year zero, a day past a thirty-day month, and February 29 in common
    // years including a century that is not a leap year.
    send_command(CMD_LOAD, 5'd0, 4'd1, YW'(2000));
    send_command(CMD_LOAD, 5'd1, 4'd0, YW'(2000));
    send_command(CMD_LOAD, 5'd1, 4'd13, YW'(2000));
    send_command(CMD_LOAD, 5'd1, 4'd15, YW'(2000));
    send_command(CMD_LOAD, 5'd1, 4'd1, '0);
    send_command(CMD_LOAD, 5'd31, 4'd4, YW'(2021));
    send_command(CMD_LOAD, 5'd29, 4'd2, YW'(2023));
    send_command(CMD_LOAD, 5'd29, 4'd2, YW'(1900));
    // Leap days: an ordinary leap year and a century divisible by 400.
    send_command(CMD_LOAD, 5'd29, 4'd2, YW'(2024));
    send_command(CMD_NEXT, 5'd0, 4'd0, '0);
    send_command(CMD_PREV, 5'd0, 4'd0, '0);
    send_command(CMD_LOAD, 5'd29, 4'd2, YW'(2000));
    // 2100 is not a leap year, so February ends on the 28th.
    send_command(CMD_LOAD, 5'd28, 4'd2, YW'(2100));
    send_command(CMD_NEXT, 5'd0, 4'd0, '0);
    send_command(CMD_PREV, 5'd0, 4'd0, '0);
    // The last day of the largest year cannot step forward.
    send_command(CMD_LOAD, 5'd31, MONTH_DEC, YEAR_MAX);
    send_command(CMD_NEXT, 5'd31, 4'd15, YEAR_MAX);
    // Year borrow and carry across the start of year 2.
    send_command(CMD_LOAD, 5'd1, MONTH_JAN, YW'(2));
    send_command(CMD_PREV, 5'd0, 4'd0, '0);
    send_command(CMD_NEXT, 5'd0, 4'd0, '0);
    // Borrow from March into February of a common year.
    send_command(CMD_LOAD, 5'd1, 4'd3, YW'(2023));
    send_command(CMD_PREV, 5'd0, 4'd0, '0);

    // Random part: mostly valid loads close to month ends or special years,
    // followed by runs of steps, with a share of random (mostly invalid) loads
    // and reads. Load fields are random on every command.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet = (i >= QUIET_FIRST && i <= QUIET_LAST);
      if (i == HOLD_AT) begin
        hold_request = 1'b1;
      end
      ld = 5'($urandom);
      lm = 4'($urandom);
      ly = YW'($urandom);
      pick = $urandom_range(99);
      if (pick < 15) begin
        cmd = CMD_LOAD;
        case ($urandom_range(3))
          0: ly = YW'($urandom_range(int'(YEAR_MAX), 1));
          1: ly = $urandom_range(1) ? YW'($urandom_range(2, 1)) :
                  YEAR_MAX - YW'($urandom_range(1));
          2: ly = YW'(100 * $urandom_range(int'(YEAR_MAX) / 100, 1));
          default: ly = YW'(4 * $urandom_range(int'(YEAR_MAX) / 4, 1));
        endcase
        lm = 4'($urandom_range(12, 1));
        month_days = calendar.days_in_month(lm, ly);
        case ($urandom_range(9))
          0: ld = month_days + 5'd1;
          1, 2: ld = 5'($urandom_range(month_days, 1));
          3: ld = DAY_FIRST;
          default: ld = month_days - 5'($urandom_range(1));
        endcase
      end else if (pick < 20) begin
        cmd = CMD_LOAD;
      end else if (pick < 57) begin
        cmd = CMD_NEXT;
      end else if (pick < 94) begin
        cmd = CMD_PREV;
      end else begin
        cmd = CMD_READ;
      end
      send_command(cmd, ld, lm, ly);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    // Drain everything owed, then give the pipeline a few more cycles so a
    // stray extra result would still be seen.
    while (calendar.pending() != 0) @(posedge clk);
    for (tail = 0; tail < 10; tail++) @(posedge clk);
    if (calendar.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: ends the run with TB_ERROR if it has not finished on its own.
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
